// ===== hdl/csa_pkg.sv =====
// Shared constants and types for the cascaded sensor averager.
package csa_pkg;
  localparam int SHORT_DEPTH = 15;
  localparam int MID_DEPTH   = 4;
  localparam int LONG_DEPTH  = 24;
  localparam int MAX_DEPTH   = (SHORT_DEPTH > MID_DEPTH) ?
                               ((SHORT_DEPTH > LONG_DEPTH) ? SHORT_DEPTH : LONG_DEPTH) :
                               ((MID_DEPTH > LONG_DEPTH) ? MID_DEPTH : LONG_DEPTH);
  localparam int TIME_W  = 32;
  localparam int TEMP_W  = 15;
  localparam int HUMID_W = 14;
  localparam int IDX_W   = $clog2(MAX_DEPTH);
  localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W   = TEMP_W + $clog2(MAX_DEPTH) + 1;
  localparam int MS_W    = $clog2(SHORT_DEPTH);
  localparam int QS_W    = $clog2(MID_DEPTH);
  localparam int HS_W    = $clog2(LONG_DEPTH);

  localparam logic [1:0] LVL_SHORT = 2'd0;
  localparam logic [1:0] LVL_MID   = 2'd1;
  localparam logic [1:0] LVL_LONG  = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DIVGO = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [HUMID_W-1:0]       humid_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [CNT_W-1:0]         cnt_t;
endpackage

// ===== hdl/csa_if.sv =====
// Valid/ready channel interfaces for sensor samples and averaged results.
interface csa_in_if;
  logic                                valid;
  logic                                ready;
  logic [csa_pkg::TIME_W-1:0]          now_ms;
  logic signed [csa_pkg::TEMP_W-1:0]   temp_in;
  logic [csa_pkg::HUMID_W-1:0]         humid_in;
  logic                                reading_ok;
  modport source (output valid, now_ms, temp_in, humid_in, reading_ok, input ready);
  modport sink (input valid, now_ms, temp_in, humid_in, reading_ok, output ready);
endinterface

interface csa_out_if;
  logic                                valid;
  logic                                ready;
  logic                                read_failed;
  logic signed [csa_pkg::TEMP_W-1:0]   temp_now;
  logic [csa_pkg::HUMID_W-1:0]         humid_now;
  logic signed [csa_pkg::TEMP_W-1:0]   temp_avg_short;
  logic signed [csa_pkg::TEMP_W-1:0]   temp_avg_mid;
  logic signed [csa_pkg::TEMP_W-1:0]   temp_avg_long;
  logic [csa_pkg::HUMID_W-1:0]         humid_avg_short;
  logic [csa_pkg::HUMID_W-1:0]         humid_avg_mid;
  logic [csa_pkg::HUMID_W-1:0]         humid_avg_long;
  modport source (output valid, read_failed, temp_now, humid_now, temp_avg_short,
                  temp_avg_mid, temp_avg_long, humid_avg_short, humid_avg_mid,
                  humid_avg_long, input ready);
  modport sink (input valid, read_failed, temp_now, humid_now, temp_avg_short,
                temp_avg_mid, temp_avg_long, humid_avg_short, humid_avg_mid,
                humid_avg_long, output ready);
endinterface

// ===== hdl/csa_div.sv =====
// Bit-serial signed-by-unsigned divider, truncating toward zero, 0 for divisor 0.
module csa_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  csa_pkg::sum_t    dividend,
  input  csa_pkg::cnt_t    divisor,
  output logic             done,
  output csa_pkg::sum_t    quotient
);
  import csa_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SUM_W-1:0]    dq_r, dq_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  cnt_t                dvs_r, dvs_nxt;
  logic                neg_r, neg_nxt;
  sum_t                q_r, q_nxt;
  logic [CNT_W:0]      rem_sh;
  logic                ge;

  // remainder stays below the divisor, so it fits in CNT_W bits
  assign rem_sh = {rem_r, dq_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W);
      dq_nxt   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
      dq_nxt   = {dq_r[SUM_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (dvs_r == '0) q_nxt = '0;
        else             q_nxt = neg_r ? -sum_t'({dq_r[SUM_W-2:0], ge})
                                       :  sum_t'({dq_r[SUM_W-2:0], ge});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// ===== hdl/cascaded_sensor_averager_top.sv =====
// Top level: sample gate, ring storage, scan sequencer and result register.
// Usage notes
//   in_ch  : one sensor sample per transaction (time, temperature, humidity, ok).
//   out_ch : one result transaction per sample that passes the interval gate;
//            a sample arriving too early is dropped with no result.
//   cfg_we / cfg_wdata : sample interval in ms, reset value 60000.
// Operation
//   A sample is gated and, if its reading is ok, written into the minute
//   rings; then each level (minute, quarter-hour, hour) is scanned one entry
//   per cycle, summed and counted, and divided by a pair of bit-serial dividers.
//   Averages cascade upward when a ring wraps.
// Flow control
//   One sample is processed at a time; in_ch.ready is high only when idle.
// Reset
//   Synchronous active-low rst_n clears all rings, slots and last timestamp.
// Stall
//   The result sits in an output register; the block returns to idle and
//   takes the next sample while it waits, and only holds in its final step
//   if a previous result is still not taken.
module cascaded_sensor_averager_top (
  input  logic                        clk,
  input  logic                        rst_n,
  csa_in_if.sink                      in_ch,
  csa_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [csa_pkg::TIME_W-1:0]  cfg_wdata
);
  import csa_pkg::*;

  state_t               state_r, state_nxt;
  logic [TIME_W-1:0]    interval_r, last_r, now_r;
  temp_t                temp_r;
  humid_t               humid_r;
  logic                 ok_r;
  logic [1:0]           level_r;
  logic [IDX_W-1:0]     idx_r;
  sum_t                 tsum_r, hsum_r;
  cnt_t                 tcnt_r, hcnt_r;
  logic [MS_W-1:0]      mslot_r;
  logic [QS_W-1:0]      qslot_r;
  logic [HS_W-1:0]      hslot_r;
  logic                 casc_q_r, casc_h_r;
  temp_t                tavg_r [3];
  humid_t               havg_r [3];

  // ring storage
  temp_t                mt_r [SHORT_DEPTH];
  humid_t               mh_r [SHORT_DEPTH];
  temp_t                qt_r [MID_DEPTH];
  humid_t               qh_r [MID_DEPTH];
  temp_t                ht_r [LONG_DEPTH];
  humid_t               hh_r [LONG_DEPTH];

  // result register
  logic                 ovalid_r, ofail_r;
  temp_t                otnow_r, ots_r, otm_r, otl_r;
  humid_t               ohnow_r, ohs_r, ohm_r, ohl_r;

  temp_t                te;
  humid_t               he;
  logic                 last_idx;
  logic                 in_acc, div_start, tdone, hdone;
  sum_t                 tq, hq;
  logic [TIME_W-1:0]    elapsed;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign div_start = (state_r == S_DIVGO);
  assign elapsed   = now_r - last_r;

  // entry under the scan pointer, and the last-index test, for the current level
  always_comb begin
    unique case (level_r)
      LVL_SHORT: begin
        te = mt_r[idx_r[MS_W-1:0]];
        he = mh_r[idx_r[MS_W-1:0]];
        last_idx = (idx_r == IDX_W'(SHORT_DEPTH - 1));
      end
      LVL_MID: begin
        te = qt_r[idx_r[QS_W-1:0]];
        he = qh_r[idx_r[QS_W-1:0]];
        last_idx = (idx_r == IDX_W'(MID_DEPTH - 1));
      end
      LVL_LONG: begin
        te = ht_r[idx_r[HS_W-1:0]];
        he = hh_r[idx_r[HS_W-1:0]];
        last_idx = (idx_r == IDX_W'(LONG_DEPTH - 1));
      end
      default: begin
        te = '0;
        he = '0;
        last_idx = 1'b1;
      end
    endcase
  end

  csa_div u_tdiv (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(tsum_r), .divisor(tcnt_r), .done(tdone), .quotient(tq)
  );

  csa_div u_hdiv (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(hsum_r), .divisor(hcnt_r), .done(hdone), .quotient(hq)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (elapsed < interval_r) ? S_IDLE : S_SCAN;
      S_SCAN:  if (last_idx) state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV: begin
        if (tdone && hdone) state_nxt = (level_r == LVL_LONG) ? S_FIN : S_SCAN;
      end
      S_FIN:   if (!ovalid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      interval_r <= TIME_W'(60000);
      last_r     <= '0;
      mslot_r    <= '0;
      qslot_r    <= '0;
      hslot_r    <= '0;
      ovalid_r   <= 1'b0;
      for (int i = 0; i < SHORT_DEPTH; i++) begin
        mt_r[i] <= '0;
        mh_r[i] <= '0;
      end
      for (int i = 0; i < MID_DEPTH; i++) begin
        qt_r[i] <= '0;
        qh_r[i] <= '0;
      end
      for (int i = 0; i < LONG_DEPTH; i++) begin
        ht_r[i] <= '0;
        hh_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) interval_r <= cfg_wdata;
      // new result loads into an empty or departing slot; else a taken result clears
      if (state_r == S_FIN && (!ovalid_r || out_ch.ready)) ovalid_r <= 1'b1;
      else if (out_ch.ready)                               ovalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r   <= in_ch.now_ms;
            temp_r  <= in_ch.temp_in;
            humid_r <= in_ch.humid_in;
            ok_r    <= in_ch.reading_ok;
          end
        end
        S_CHECK: begin
          level_r  <= LVL_SHORT;
          idx_r    <= '0;
          tsum_r   <= '0;
          hsum_r   <= '0;
          tcnt_r   <= '0;
          hcnt_r   <= '0;
          casc_h_r <= 1'b0;
          // minute ring wraps on this sample: its average goes up a level
          casc_q_r <= (elapsed >= interval_r) && ok_r &&
                      (mslot_r == MS_W'(SHORT_DEPTH - 1));
          if (elapsed >= interval_r) begin
            last_r <= now_r;
            if (ok_r) begin
              mt_r[mslot_r] <= temp_r;
              mh_r[mslot_r] <= humid_r;
              if (mslot_r == MS_W'(SHORT_DEPTH - 1)) begin
                mslot_r  <= '0;
              end else begin
                mslot_r <= mslot_r + 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          tsum_r <= tsum_r + SUM_W'(te);
          hsum_r <= hsum_r + SUM_W'({1'b0, he});
          tcnt_r <= tcnt_r + CNT_W'(te != '0);
          hcnt_r <= hcnt_r + CNT_W'(he != '0);
          idx_r  <= idx_r + 1'b1;
        end
        S_DIVGO: ;
        S_DIV: begin
          if (tdone && hdone) begin
            tavg_r[level_r] <= tq[TEMP_W-1:0];
            havg_r[level_r] <= hq[HUMID_W-1:0];
            // cascade the fresh average one level up when the ring below wrapped
            if (level_r == LVL_SHORT && casc_q_r) begin
              qt_r[qslot_r] <= tq[TEMP_W-1:0];
              qh_r[qslot_r] <= hq[HUMID_W-1:0];
              if (qslot_r == QS_W'(MID_DEPTH - 1)) begin
                qslot_r  <= '0;
                casc_h_r <= 1'b1;
              end else begin
                qslot_r <= qslot_r + 1'b1;
              end
            end
            if (level_r == LVL_MID && casc_h_r) begin
              ht_r[hslot_r] <= tq[TEMP_W-1:0];
              hh_r[hslot_r] <= hq[HUMID_W-1:0];
              if (hslot_r == HS_W'(LONG_DEPTH - 1)) hslot_r <= '0;
              else                                  hslot_r <= hslot_r + 1'b1;
            end
            level_r <= level_r + 1'b1;
            idx_r   <= '0;
            tsum_r  <= '0;
            hsum_r  <= '0;
            tcnt_r  <= '0;
            hcnt_r  <= '0;
          end
        end
        S_FIN: begin
          if (!ovalid_r || out_ch.ready) begin
            ofail_r  <= !ok_r;
            otnow_r  <= ok_r ? temp_r : '0;
            ohnow_r  <= ok_r ? humid_r : '0;
            ots_r    <= tavg_r[LVL_SHORT];
            otm_r    <= tavg_r[LVL_MID];
            otl_r    <= tavg_r[LVL_LONG];
            ohs_r    <= havg_r[LVL_SHORT];
            ohm_r    <= havg_r[LVL_MID];
            ohl_r    <= havg_r[LVL_LONG];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = ovalid_r;
  assign out_ch.read_failed     = ofail_r;
  assign out_ch.temp_now        = otnow_r;
  assign out_ch.humid_now       = ohnow_r;
  assign out_ch.temp_avg_short  = ots_r;
  assign out_ch.temp_avg_mid    = otm_r;
  assign out_ch.temp_avg_long   = otl_r;
  assign out_ch.humid_avg_short = ohs_r;
  assign out_ch.humid_avg_mid   = ohm_r;
  assign out_ch.humid_avg_long  = ohl_r;
endmodule

// ===== sim/testbench.sv =====
// Testbench for the cascaded sensor averager: directed and random samples, scoreboard check.
`timescale 1ns / 100ps

module testbench;
  import csa_pkg::*;

  typedef struct packed {
    logic   read_failed;
    temp_t  temp_now;
    humid_t humid_now;
    temp_t  temp_avg_short;
    temp_t  temp_avg_mid;
    temp_t  temp_avg_long;
    humid_t humid_avg_short;
    humid_t humid_avg_mid;
    humid_t humid_avg_long;
  } avg_result_t;

  // Scoreboard: mirrors the ring cascade and holds the averages still owed by the block.
  class avg_scoreboard;
    logic [TIME_W-1:0] interval_ms;
    logic [TIME_W-1:0] last_time;
    int minute_t[SHORT_DEPTH], minute_h[SHORT_DEPTH];
    int quarter_t[MID_DEPTH],  quarter_h[MID_DEPTH];
    int hour_t[LONG_DEPTH],    hour_h[LONG_DEPTH];
    int minute_pos, quarter_pos, hour_pos;
    avg_result_t pending[$];
    int errors;

    function new();
      interval_ms = 32'd60000;
      last_time   = '0;
      foreach (minute_t[i]) begin minute_t[i] = 0; minute_h[i] = 0; end
      foreach (quarter_t[i]) begin quarter_t[i] = 0; quarter_h[i] = 0; end
      foreach (hour_t[i]) begin hour_t[i] = 0; hour_h[i] = 0; end
      minute_pos = 0; quarter_pos = 0; hour_pos = 0;
      errors = 0;
    endfunction

    // Mean over nonzero entries only; SV int division truncates toward zero.
    function int nz_mean(int vals[], int depth);
      int sum, cnt;
      sum = 0; cnt = 0;
      for (int i = 0; i < depth; i++) begin
        sum += vals[i];
        if (vals[i] != 0) cnt++;
      end
      return (cnt == 0) ? 0 : sum / cnt;
    endfunction

    // Note an accepted sample transaction; queue a result if it passes the gate.
    function void note_sample(logic [TIME_W-1:0] now, temp_t t, humid_t h, logic ok);
      avg_result_t r;
      logic [TIME_W-1:0] diff;
      diff = now - last_time;
      if (diff < interval_ms) return;
      last_time = now;
      r = '0;
      r.read_failed = !ok;
      if (ok) begin
        r.temp_now  = t;
        r.humid_now = h;
        minute_t[minute_pos] = int'(t);
        minute_h[minute_pos] = int'(h);
        minute_pos = (minute_pos + 1 >= SHORT_DEPTH) ? 0 : minute_pos + 1;
        if (minute_pos == 0) begin
          quarter_t[quarter_pos] = nz_mean(minute_t, SHORT_DEPTH);
          quarter_h[quarter_pos] = nz_mean(minute_h, SHORT_DEPTH);
          quarter_pos = (quarter_pos + 1 >= MID_DEPTH) ? 0 : quarter_pos + 1;
          if (quarter_pos == 0) begin
            hour_t[hour_pos] = nz_mean(quarter_t, MID_DEPTH);
            hour_h[hour_pos] = nz_mean(quarter_h, MID_DEPTH);
            hour_pos = (hour_pos + 1 >= LONG_DEPTH) ? 0 : hour_pos + 1;
          end
        end
      end
      r.temp_avg_short  = temp_t'(nz_mean(minute_t, SHORT_DEPTH));
      r.temp_avg_mid    = temp_t'(nz_mean(quarter_t, MID_DEPTH));
      r.temp_avg_long   = temp_t'(nz_mean(hour_t, LONG_DEPTH));
      r.humid_avg_short = humid_t'(nz_mean(minute_h, SHORT_DEPTH));
      r.humid_avg_mid   = humid_t'(nz_mean(quarter_h, MID_DEPTH));
      r.humid_avg_long  = humid_t'(nz_mean(hour_h, LONG_DEPTH));
      pending.push_back(r);
    endfunction

    function void check_result(avg_result_t got);
      avg_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.read_failed !== exp_r.read_failed) begin
        $error("read_failed exp %0d got %0d", exp_r.read_failed, got.read_failed); errors++;
      end
      if (got.temp_now !== exp_r.temp_now) begin
        $error("temp_now exp %0d got %0d", exp_r.temp_now, got.temp_now); errors++;
      end
      if (got.humid_now !== exp_r.humid_now) begin
        $error("humid_now exp %0d got %0d", exp_r.humid_now, got.humid_now); errors++;
      end
      if (got.temp_avg_short !== exp_r.temp_avg_short) begin
        $error("temp_avg_short exp %0d got %0d", exp_r.temp_avg_short, got.temp_avg_short);
        errors++;
      end
      if (got.temp_avg_mid !== exp_r.temp_avg_mid) begin
        $error("temp_avg_mid exp %0d got %0d", exp_r.temp_avg_mid, got.temp_avg_mid);
        errors++;
      end
      if (got.temp_avg_long !== exp_r.temp_avg_long) begin
        $error("temp_avg_long exp %0d got %0d", exp_r.temp_avg_long, got.temp_avg_long);
        errors++;
      end
      if (got.humid_avg_short !== exp_r.humid_avg_short) begin
        $error("humid_avg_short exp %0d got %0d", exp_r.humid_avg_short, got.humid_avg_short);
        errors++;
      end
      if (got.humid_avg_mid !== exp_r.humid_avg_mid) begin
        $error("humid_avg_mid exp %0d got %0d", exp_r.humid_avg_mid, got.humid_avg_mid);
        errors++;
      end
      if (got.humid_avg_long !== exp_r.humid_avg_long) begin
        $error("humid_avg_long exp %0d got %0d", exp_r.humid_avg_long, got.humid_avg_long);
        errors++;
      end
    endfunction
  endclass

  // Generous bound: all 416 samples, with their scans and stalls, fit well below this.
  localparam int CYCLE_LIMIT = 600000;
  // Quiet time before a register write: covers the gate drop and any tail of a busy scan.
  localparam int SETTLE_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  csa_in_if  in_ch();
  csa_out_if out_ch();

  avg_scoreboard sb = new();

  cascaded_sensor_averager_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check on each completed transaction, then pick the next ready level.
  // Values read here are the pre-edge ones, so the check sees what the edge accepted.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.read_failed, out_ch.temp_now, out_ch.humid_now,
                        out_ch.temp_avg_short, out_ch.temp_avg_mid, out_ch.temp_avg_long,
                        out_ch.humid_avg_short, out_ch.humid_avg_mid,
                        out_ch.humid_avg_long});
    end
    out_ch.ready <= rst_n && ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Send one sample. valid stays high across back-to-back transactions.
  task automatic send_sample(logic [TIME_W-1:0] now, temp_t t, humid_t h, logic ok);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.now_ms     <= now;
    in_ch.temp_in    <= t;
    in_ch.humid_in   <= h;
    in_ch.reading_ok <= ok;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(now, t, h, ok);
  endtask

  // Drain outstanding results, let the block settle, then write the interval register.
  task automatic set_interval(logic [TIME_W-1:0] ms);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.interval_ms = ms;
  endtask

  function automatic temp_t pick_temp();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 8) return '0;
    if (sel < 20) return temp_t'($urandom);
    return temp_t'($urandom_range(16500, 0) - 4000);
  endfunction

  function automatic humid_t pick_humid();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 8) return '0;
    if (sel < 20) return humid_t'($urandom);
    return humid_t'($urandom_range(10000, 0));
  endfunction

  // Timestamp: mostly a legal spacing, sometimes too early, sometimes anywhere.
  function automatic logic [TIME_W-1:0] pick_time();
    int sel;
    logic [TIME_W-1:0] iv;
    iv  = sb.interval_ms;
    sel = $urandom_range(99, 0);
    if (sel < 80) return sb.last_time + iv + $urandom_range(50, 0);
    if (sel < 92 && iv > 1) return sb.last_time + $urandom_range(iv - 1, 0);
    return $urandom;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_sample(pick_time(), pick_temp(), pick_humid(), $urandom_range(99, 0) < 88);
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.now_ms     <= '0;
    in_ch.temp_in    <= '0;
    in_ch.humid_in   <= '0;
    in_ch.reading_ok <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset interval: time 0 is too soon after the zero last timestamp.
    send_sample(32'd0, 15'sd2000, 14'd5000, 1'b1);
    send_sample(32'd60000, -15'sd4000, 14'd0, 1'b1);          // coldest, zero humidity
    send_sample(32'd120000, 15'sd12500, 14'd10000, 1'b1);     // hottest, full humidity
    send_sample(32'd120001, 15'sd100, 14'd100, 1'b1);         // too early: dropped
    send_sample(32'd180000, 15'sd0, 14'd0, 1'b1);             // zero reading stored
    send_sample(32'd240000, 15'sd777, 14'd333, 1'b0);         // failed read
    send_sample(32'd300000, 15'sh4000, 14'd16383, 1'b1);      // out of range extremes
    send_sample(32'd360000, 15'sd16383, 14'd8191, 1'b1);
    send_sample(32'hFFFF_FFF0, -15'sd1, 14'd1, 1'b1);         // large jump

    // Zero interval: every sample passes, even at the same timestamp.
    set_interval(32'd0);
    send_sample(32'hFFFF_FFF0, 15'sd5, 14'd5, 1'b1);
    send_sample(32'd10, 15'sd6, 14'd6, 1'b1);                 // wraps past zero
    send_sample(32'd10, 15'sd0, 14'd0, 1'b0);

    // Largest interval: only a difference of all ones passes.
    set_interval(32'hFFFF_FFFF);
    send_sample(32'd20, 15'sd9, 14'd9, 1'b1);
    send_sample(32'd9, 15'sd10, 14'd10, 1'b1);

    set_interval(32'd1);
    send_sample(sb.last_time, 15'sd11, 14'd11, 1'b1);
    send_sample(sb.last_time + 1, 15'sd12, 14'd12, 1'b1);

    // Random phases, each with its own interval and idling pattern.
    set_interval(32'd60000);
    send_idle_pct = 22; recv_idle_pct = 64;
    random_phase(130);

    set_interval($urandom_range(100000, 2));
    send_idle_pct = 64; recv_idle_pct = 22;
    random_phase(130);

    set_interval(32'd0);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(70);
    set_interval(32'd1);
    random_phase(70);

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/csa_pkg.sv
hdl/csa_if.sv
hdl/csa_div.sv
hdl/cascaded_sensor_averager_top.sv
sim/testbench.sv
